// ===== design/assert_macros.svh =====
// Assertion macros of the word CPU core, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WCPU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define WCPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define WCPU_ASSERT(lbl, clk, rstn, prop, msg)
`define WCPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/wcpu_pkg.sv =====
// Package of the word CPU core: codes, operand kinds and controller/datapath structs.
package wcpu_pkg;
	localparam int MEM_WORDS_DEF = 65536;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;
	localparam logic [1:0] CMD_REGRD = 2'd3;

	localparam logic [3:0] OP_NB  = 4'h0;
	localparam logic [3:0] OP_SET = 4'h1;
	localparam logic [3:0] OP_ADD = 4'h2;
	localparam logic [3:0] OP_SUB = 4'h3;
	localparam logic [3:0] OP_MUL = 4'h4;
	localparam logic [3:0] OP_DIV = 4'h5;
	localparam logic [3:0] OP_MOD = 4'h6;
	localparam logic [3:0] OP_SHL = 4'h7;
	localparam logic [3:0] OP_SHR = 4'h8;
	localparam logic [3:0] OP_AND = 4'h9;
	localparam logic [3:0] OP_BOR = 4'hA;
	localparam logic [3:0] OP_XOR = 4'hB;
	localparam logic [3:0] OP_IFE = 4'hC;
	localparam logic [3:0] OP_IFN = 4'hD;
	localparam logic [3:0] OP_IFG = 4'hE;
	localparam logic [3:0] OP_IFB = 4'hF;

	localparam logic [5:0] NB_JSR = 6'h01;

	localparam logic [3:0] SEL_SP = 4'd8;
	localparam logic [3:0] SEL_PC = 4'd9;
	localparam logic [3:0] SEL_O  = 4'd10;

	typedef enum logic [2:0] {
		LOC_REG, LOC_SP, LOC_PC, LOC_O, LOC_MEM, LOC_LIT
	} loc_kind_t;

	typedef enum logic [2:0] {
		MEM_NONE, MEM_RD_PC, MEM_RD_LOC, MEM_RD_CMD, MEM_WR_CMD, MEM_WR_RES, MEM_WR_JSR
	} mem_op_t;

	typedef struct packed {
		logic     latch_in;
		mem_op_t  mem_op;
		logic     pc_inc;
		logic     cap_instr;
		logic     cap_nw;
		logic     dec_loc;
		logic     cap_val;
		logic     val_mem;
		logic     sel_b;
		logic     exec;
		logic     div_fin;
		logic     wb;
		logic     skip_pc;
		logic     jsr_sp;
		logic     jsr_pc;
		logic     cap_rd_mem;
		logic     cap_rd_reg;
		logic     set_rsv;
		logic     load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       reserved;
		logic       is_basic;
		logic       needs_nw;
		logic       cur_is_mem;
		logic       is_jsr;
		logic       is_divmod;
		logic       test_fail;
		logic       div_busy;
	} dp_status_t;

	function automatic logic needs_next_word(input logic [5:0] code);
		return (code[5:3] == 3'b010) || (code == 6'h1E) || (code == 6'h1F);
	endfunction
endpackage

// ===== design/wcpu_ram.sv =====
// Generic single-port RAM with registered read.
module wcpu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== design/wcpu_datapath.sv =====
// Datapath of the word CPU core: registers, operand decode, ALU, divider and memory.
module wcpu_datapath import wcpu_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  st,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [15:0] data,
	input  logic [3:0]  reg_select,
	output logic [15:0] read_data,
	output logic [15:0] program_counter,
	output logic [15:0] overflow_word,
	output logic        reserved_op
);
	localparam int AW = $clog2(MEM_WORDS);

	logic [15:0] gr_q [8];
	logic [15:0] sp_q, pc_q, o_q;
	logic [1:0]  cmd_q;
	logic [15:0] addr_q, data_q;
	logic [3:0]  sel_q;
	logic [15:0] instr_q, nw_q;
	loc_kind_t   kind_a_q, kind_b_q;
	logic [15:0] loc_a_q, loc_b_q, av_q, bv_q;
	logic [15:0] res_q, newo_q, rd_q;
	logic        sets_o_q, writes_q, test_fail_q, rsv_q;
	logic [16:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;

	logic [3:0]  opc;
	logic [5:0]  code_cur;
	loc_kind_t   kind_cur, dec_kind;
	logic [15:0] loc_cur, dec_v, dec_sp, direct_val, mem_rdata;
	logic        mem_we;
	logic [15:0] mem_addr, mem_wdata;

	assign opc      = instr_q[3:0];
	assign code_cur = (cmd.sel_b || opc == OP_NB) ? instr_q[15:10] : instr_q[9:4];
	assign kind_cur = cmd.sel_b ? kind_b_q : kind_a_q;
	assign loc_cur  = cmd.sel_b ? loc_b_q : loc_a_q;

	assign st.cmd        = cmd_q;
	assign st.is_basic   = opc != OP_NB;
	assign st.reserved   = (opc == OP_NB) && (instr_q[9:4] != NB_JSR);
	assign st.is_jsr     = (opc == OP_NB) && (instr_q[9:4] == NB_JSR);
	assign st.needs_nw   = needs_next_word(code_cur);
	assign st.cur_is_mem = kind_cur == LOC_MEM;
	assign st.is_divmod  = (opc == OP_DIV) || (opc == OP_MOD);
	assign st.test_fail  = test_fail_q;
	assign st.div_busy   = busy_q;

	// Operand decode, including the stack pointer side effects.
	always_comb begin
		dec_kind = LOC_LIT;
		dec_v    = 16'd0;
		dec_sp   = sp_q;
		case (code_cur) inside
			[6'h00:6'h07]: begin dec_kind = LOC_REG; dec_v = {10'd0, code_cur}; end
			[6'h08:6'h0F]: begin dec_kind = LOC_MEM; dec_v = gr_q[code_cur[2:0]]; end
			[6'h10:6'h17]: begin dec_kind = LOC_MEM; dec_v = nw_q + gr_q[code_cur[2:0]]; end
			6'h18: begin dec_kind = LOC_MEM; dec_v = sp_q; dec_sp = sp_q + 16'd1; end
			6'h19: begin dec_kind = LOC_MEM; dec_v = sp_q; end
			6'h1A: begin dec_kind = LOC_MEM; dec_v = sp_q - 16'd1; dec_sp = sp_q - 16'd1; end
			6'h1B: dec_kind = LOC_SP;
			6'h1C: dec_kind = LOC_PC;
			6'h1D: dec_kind = LOC_O;
			6'h1E: begin dec_kind = LOC_MEM; dec_v = nw_q; end
			6'h1F: begin dec_kind = LOC_LIT; dec_v = nw_q; end
			default: begin dec_kind = LOC_LIT; dec_v = {11'd0, code_cur[4:0]}; end
		endcase
	end

	always_comb begin
		case (kind_cur)
			LOC_REG: direct_val = gr_q[loc_cur[2:0]];
			LOC_SP:  direct_val = sp_q;
			LOC_PC:  direct_val = pc_q;
			LOC_O:   direct_val = o_q;
			default: direct_val = loc_cur;
		endcase
	end

	// ALU for everything but the divider results.
	logic [16:0] sum;
	logic [31:0] prod, shl_t, shr_t;
	logic        big_shift;
	logic [15:0] alu_res, alu_newo;
	logic        alu_sets_o, alu_writes, alu_fail;

	assign sum       = {1'b0, av_q} + {1'b0, bv_q};
	assign prod      = av_q * bv_q;
	assign big_shift = |bv_q[15:5];
	assign shl_t     = big_shift ? 32'd0 : ({16'd0, av_q} << bv_q[4:0]);
	assign shr_t     = big_shift ? 32'd0 : ({av_q, 16'd0} >> bv_q[4:0]);

	always_comb begin
		alu_res    = 16'd0;
		alu_newo   = 16'd0;
		alu_sets_o = 1'b0;
		alu_writes = 1'b1;
		alu_fail   = 1'b0;
		case (opc)
			OP_SET: alu_res = bv_q;
			OP_ADD: begin alu_res = sum[15:0]; alu_sets_o = 1'b1; alu_newo = {15'd0, sum[16]}; end
			OP_SUB: begin
				alu_res    = av_q - bv_q;
				alu_sets_o = 1'b1;
				alu_newo   = (av_q < bv_q) ? 16'hFFFF : 16'h0000;
			end
			OP_MUL: begin alu_res = prod[15:0]; alu_sets_o = 1'b1; alu_newo = prod[31:16]; end
			OP_DIV: alu_sets_o = 1'b1;
			OP_MOD: alu_sets_o = 1'b0;
			OP_SHL: begin alu_res = shl_t[15:0]; alu_sets_o = 1'b1; alu_newo = shl_t[31:16]; end
			OP_SHR: begin alu_res = shr_t[31:16]; alu_sets_o = 1'b1; alu_newo = shr_t[15:0]; end
			OP_AND: alu_res = av_q & bv_q;
			OP_BOR: alu_res = av_q | bv_q;
			OP_XOR: alu_res = av_q ^ bv_q;
			OP_IFE: begin alu_writes = 1'b0; alu_fail = !(av_q == bv_q); end
			OP_IFN: begin alu_writes = 1'b0; alu_fail = !(av_q != bv_q); end
			OP_IFG: begin alu_writes = 1'b0; alu_fail = !(av_q > bv_q); end
			default: begin alu_writes = 1'b0; alu_fail = ((av_q & bv_q) == 16'd0); end
		endcase
	end

	// Restoring divider step: one quotient bit per cycle.
	logic [16:0] div_r;
	logic        div_ge;
	assign div_r  = {rem_q[15:0], quo_q[31]};
	assign div_ge = div_r >= {1'b0, bv_q};

	// Skip length of the instruction at PC.
	logic [1:0] skip_len;
	always_comb begin
		if (mem_rdata[3:0] == OP_NB) begin
			skip_len = 2'd1 + {1'b0, needs_next_word(mem_rdata[15:10])};
		end else begin
			skip_len = 2'd1 + {1'b0, needs_next_word(mem_rdata[9:4])}
				+ {1'b0, needs_next_word(mem_rdata[15:10])};
		end
	end

	always_comb begin
		mem_addr  = 16'd0;
		mem_wdata = res_q;
		mem_we    = 1'b0;
		case (cmd.mem_op)
			MEM_RD_PC:  mem_addr = pc_q;
			MEM_RD_LOC: mem_addr = loc_cur;
			MEM_RD_CMD: mem_addr = addr_q;
			MEM_WR_CMD: begin mem_addr = addr_q; mem_wdata = data_q; mem_we = 1'b1; end
			MEM_WR_RES: begin
				mem_addr = loc_a_q;
				mem_we   = writes_q && (kind_a_q == LOC_MEM);
			end
			MEM_WR_JSR: begin mem_addr = sp_q; mem_wdata = pc_q; mem_we = 1'b1; end
			default: mem_addr = 16'd0;
		endcase
	end

	wcpu_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr[AW-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) gr_q[i] <= 16'd0;
			sp_q   <= 16'd0;
			pc_q   <= 16'd0;
			o_q    <= 16'd0;
			busy_q <= 1'b0;
		end else begin
			if (cmd.pc_inc) pc_q <= pc_q + 16'd1;
			if (cmd.dec_loc) sp_q <= dec_sp;
			if (cmd.skip_pc) pc_q <= pc_q + {14'd0, skip_len};
			if (cmd.jsr_sp) sp_q <= sp_q - 16'd1;
			if (cmd.jsr_pc) pc_q <= av_q;
			if (cmd.wb) begin
				if (writes_q) begin
					case (kind_a_q)
						LOC_REG: gr_q[loc_a_q[2:0]] <= res_q;
						LOC_SP:  sp_q <= res_q;
						LOC_PC:  pc_q <= res_q;
						// The new O wins over a destination of O.
						LOC_O:   if (!sets_o_q) o_q <= res_q;
						default: ;
					endcase
				end
				if (sets_o_q) o_q <= newo_q;
			end
			if (cmd.exec && st.is_divmod) begin
				busy_q <= bv_q != 16'd0;
			end else if (busy_q && cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q  <= command;
			addr_q <= address;
			data_q <= data;
			sel_q  <= reg_select;
			rd_q   <= 16'd0;
			rsv_q  <= 1'b0;
		end
		if (cmd.cap_instr) instr_q <= mem_rdata;
		if (cmd.cap_nw) nw_q <= mem_rdata;
		if (cmd.dec_loc) begin
			if (cmd.sel_b) begin
				kind_b_q <= dec_kind;
				loc_b_q  <= dec_v;
			end else begin
				kind_a_q <= dec_kind;
				loc_a_q  <= dec_v;
			end
		end
		if (cmd.cap_val) begin
			if (cmd.sel_b) bv_q <= cmd.val_mem ? mem_rdata : direct_val;
			else av_q <= cmd.val_mem ? mem_rdata : direct_val;
		end
		if (cmd.exec) begin
			res_q       <= alu_res;
			newo_q      <= alu_newo;
			sets_o_q    <= alu_sets_o;
			writes_q    <= alu_writes;
			test_fail_q <= alu_fail;
			if (st.is_divmod) begin
				rem_q <= 17'd0;
				cnt_q <= 5'd0;
				if (bv_q == 16'd0) quo_q <= 32'd0;
				else if (opc == OP_DIV) quo_q <= {av_q, 16'd0};
				else quo_q <= {16'd0, av_q};
			end
		end else if (busy_q) begin
			rem_q <= div_ge ? (div_r - {1'b0, bv_q}) : div_r;
			quo_q <= {quo_q[30:0], div_ge};
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.div_fin) begin
			res_q  <= (opc == OP_DIV) ? quo_q[31:16] : rem_q[15:0];
			newo_q <= quo_q[15:0];
		end
		if (cmd.cap_rd_mem) rd_q <= mem_rdata;
		if (cmd.cap_rd_reg) begin
			case (sel_q) inside
				[4'd0:4'd7]: rd_q <= gr_q[sel_q[2:0]];
				SEL_SP:      rd_q <= sp_q;
				SEL_PC:      rd_q <= pc_q;
				SEL_O:       rd_q <= o_q;
				default:     rd_q <= 16'd0;
			endcase
		end
		if (cmd.set_rsv) rsv_q <= 1'b1;
		if (cmd.load_out) begin
			read_data       <= rd_q;
			program_counter <= pc_q;
			overflow_word   <= o_q;
			reserved_op     <= rsv_q;
		end
	end
endmodule

// ===== design/wcpu_ctrl.sv =====
// Controller state machine of the word CPU core.
module wcpu_ctrl import wcpu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_MEMWR, ST_MEMRD, ST_MEMRD_W, ST_REGRD, ST_FETCH, ST_FETCH_W,
		ST_DEC, ST_NW_W, ST_LOC, ST_RD, ST_RD_W, ST_EXEC, ST_DIV, ST_WB,
		ST_SKIP, ST_SKIP_W, ST_JSR, ST_JSR_W, ST_DONE
	} state_t;

	state_t state_q;
	logic   sel_b_q, out_valid_q;
	logic   accept, more_b;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign more_b    = !sel_b_q && st.is_basic;

	always_comb begin
		cmd          = '0;
		cmd.mem_op   = MEM_NONE;
		cmd.sel_b    = sel_b_q;
		cmd.latch_in = accept;
		case (state_q)
			ST_MEMWR:   cmd.mem_op = MEM_WR_CMD;
			ST_MEMRD:   cmd.mem_op = MEM_RD_CMD;
			ST_MEMRD_W: cmd.cap_rd_mem = 1'b1;
			ST_REGRD:   cmd.cap_rd_reg = 1'b1;
			ST_FETCH: begin cmd.mem_op = MEM_RD_PC; cmd.pc_inc = 1'b1; end
			ST_FETCH_W: cmd.cap_instr = 1'b1;
			ST_DEC: begin
				if (st.reserved) begin
					cmd.set_rsv = 1'b1;
				end else if (st.needs_nw) begin
					cmd.mem_op = MEM_RD_PC;
					cmd.pc_inc = 1'b1;
				end
			end
			ST_NW_W:    cmd.cap_nw = 1'b1;
			ST_LOC:     cmd.dec_loc = 1'b1;
			ST_RD: begin
				if (st.cur_is_mem) cmd.mem_op = MEM_RD_LOC;
				else cmd.cap_val = 1'b1;
			end
			ST_RD_W: begin cmd.cap_val = 1'b1; cmd.val_mem = 1'b1; end
			ST_EXEC:    cmd.exec = !st.is_jsr;
			ST_DIV:     cmd.div_fin = !st.div_busy;
			ST_WB: begin cmd.wb = 1'b1; cmd.mem_op = MEM_WR_RES; end
			ST_SKIP:    cmd.mem_op = MEM_RD_PC;
			ST_SKIP_W:  cmd.skip_pc = 1'b1;
			ST_JSR:     cmd.jsr_sp = 1'b1;
			ST_JSR_W: begin cmd.mem_op = MEM_WR_JSR; cmd.jsr_pc = 1'b1; end
			ST_DONE:    cmd.load_out = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					sel_b_q <= 1'b0;
					if (accept) state_q <= ST_DISP;
				end
				// The command is in its register from here on.
				ST_DISP: begin
					case (st.cmd)
						CMD_WRITE: state_q <= ST_MEMWR;
						CMD_READ:  state_q <= ST_MEMRD;
						CMD_STEP:  state_q <= ST_FETCH;
						default:   state_q <= ST_REGRD;
					endcase
				end
				ST_MEMWR:   state_q <= ST_DONE;
				ST_MEMRD:   state_q <= ST_MEMRD_W;
				ST_MEMRD_W: state_q <= ST_DONE;
				ST_REGRD:   state_q <= ST_DONE;
				ST_FETCH:   state_q <= ST_FETCH_W;
				ST_FETCH_W: state_q <= ST_DEC;
				ST_DEC: begin
					if (st.reserved) state_q <= ST_DONE;
					else if (st.needs_nw) state_q <= ST_NW_W;
					else state_q <= ST_LOC;
				end
				ST_NW_W:    state_q <= ST_LOC;
				ST_LOC: begin
					if (more_b) begin
						sel_b_q <= 1'b1;
						state_q <= ST_DEC;
					end else begin
						sel_b_q <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD, ST_RD_W: begin
					if (state_q == ST_RD && st.cur_is_mem) begin
						state_q <= ST_RD_W;
					end else if (more_b) begin
						sel_b_q <= 1'b1;
						state_q <= ST_RD;
					end else begin
						sel_b_q <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (st.is_jsr) state_q <= ST_JSR;
					else if (st.is_divmod) state_q <= ST_DIV;
					else state_q <= ST_WB;
				end
				ST_DIV:     if (!st.div_busy) state_q <= ST_WB;
				ST_WB:      state_q <= st.test_fail ? ST_SKIP : ST_DONE;
				ST_SKIP:    state_q <= ST_SKIP_W;
				ST_SKIP_W:  state_q <= ST_DONE;
				ST_JSR:     state_q <= ST_JSR_W;
				ST_JSR_W:   state_q <= ST_DONE;
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/word_cpu_instruction_executor.sv =====
// Top level of the word CPU core: controller, datapath and checks.

// A 16-bit word CPU core of the version 1.1 instruction set. Each input word
// carries one command: write a memory word, read a memory word, read a
// register (0-7 general registers, 8 SP, 9 PC, 10 O, others read as 0), or
// fetch and execute one instruction at PC. Every command returns exactly one
// result word with the read value (zero for write and step), PC, O and a flag
// for a reserved non-basic opcode, which executes as a no-op. The block
// handles one command at a time, and a new command is taken only once the
// previous result has been delivered. A step runs through dispatch, the
// instruction fetch, the decode of each operand with its next-word read,
// the operand reads, execute and writeback, then the skip lookahead after
// a failed test; JSR pushes PC in place of writeback. The single memory
// port serialises the memory reads, each of which is issued and then
// waited for. DIV and MOD wait on the bit-serial divider, which is skipped
// when dividing by zero. Memory is MEM_WORDS deep (a power of two);
// addresses use its low bits, and a word must be written before it is read.
module word_cpu_instruction_executor import wcpu_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [15:0] data,
	input  logic [3:0]  reg_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_data,
	output logic [15:0] program_counter,
	output logic [15:0] overflow_word,
	output logic        reserved_op
);
`include "assert_macros.svh"

	ctrl_cmd_t  cmd;
	dp_status_t st;

	// The controller sequences every command; the datapath only acts on its commands.
	wcpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	wcpu_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.command         (command),
		.address         (address),
		.data            (data),
		.reg_select      (reg_select),
		.read_data       (read_data),
		.program_counter (program_counter),
		.overflow_word   (overflow_word),
		.reserved_op     (reserved_op)
	);

	// A new word is never taken while a result is still waiting.
	`WCPU_ASSERT(a_ready_no_pending, clk, arst_n, !(in_ready && out_valid), "ready with result pending")
	// Once a word is accepted, the block is busy in the next cycle.
	`WCPU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	// The memory port stays quiet while the divider iterates.
	`WCPU_ASSERT(a_no_mem_in_div, clk, arst_n, !(st.div_busy && cmd.mem_op != MEM_NONE), "memory access during divide")
endmodule

// ===== verif/word_cpu_instruction_executor_tb.sv =====
// Self-checking testbench of the word CPU core: directed programs, then random commands.
module word_cpu_instruction_executor_tb;
	import wcpu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Operand codes with a meaning of their own in the instruction set.
	localparam logic [5:0] OPD_NW_REG = 6'h10;
	localparam logic [5:0] OPD_POP    = 6'h18;
	localparam logic [5:0] OPD_PEEK   = 6'h19;
	localparam logic [5:0] OPD_PUSH   = 6'h1A;
	localparam logic [5:0] OPD_SP     = 6'h1B;
	localparam logic [5:0] OPD_PC     = 6'h1C;
	localparam logic [5:0] OPD_O      = 6'h1D;
	localparam logic [5:0] OPD_NW_MEM = 6'h1E;
	localparam logic [5:0] OPD_NW_LIT = 6'h1F;
	localparam logic [5:0] OPD_LIT0   = 6'h20;
	localparam logic [5:0] OPD_LIT1   = 6'h21;
	localparam logic [5:0] OPD_LIT5   = 6'h25;
	localparam logic [5:0] NB_RSV     = 6'h02;

	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_WORDS = 1100;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AT      = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 800000;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [15:0] wdata;
		logic [3:0]  sel;
	} cmd_word_t;

	typedef struct {
		logic [15:0] rd;
		logic [15:0] pc;
		logic [15:0] ovf;
		logic        rsv;
	} cpu_result_t;

	typedef struct {
		loc_kind_t   kind;
		logic [15:0] v;
	} operand_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [15:0] data;
	logic [3:0]  reg_select;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] read_data;
	logic [15:0] program_counter;
	logic [15:0] overflow_word;
	logic        reserved_op;

	word_cpu_instruction_executor u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.address         (address),
		.data            (data),
		.reg_select      (reg_select),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.read_data       (read_data),
		.program_counter (program_counter),
		.overflow_word   (overflow_word),
		.reserved_op     (reserved_op)
	);

	// Architectural state of the CPU as the checker sees it.
	logic [15:0] cpu_regs [8];
	logic [15:0] cpu_sp;
	logic [15:0] cpu_pc;
	logic [15:0] cpu_o;
	logic [15:0] mem_image [int];
	int          written_addrs [$];

	// A trial execution keeps memory untouched: its single store is held
	// aside, and every read of a never-written word is noted so that the
	// stimulus can write that word first.
	bit          trial;
	bit          held_valid;
	logic [15:0] held_addr;
	logic [15:0] held_data;
	int          unwritten_reads [$];

	cmd_word_t   command_queue [$];
	cpu_result_t result_queue [$];

	int  n_fail;
	int  n_results;
	int  n_reserved;
	int  n_cmd [4];
	int  cycle_count;
	bit  in_took;
	bit  out_took;
	int  send_gap;
	int  recv_stall;
	int  hold_left;
	bit  hold_done;
	bit  send_quiet;
	bit  recv_quiet;
	bit  stimulus_done;
	cmd_word_t drv_word;

	// The clock runs from time zero; reset is held low from the start and released on a falling clock edge.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] mem_load(input logic [15:0] a);
		if (held_valid && held_addr == a)
			return held_data;
		if (mem_image.exists(a))
			return mem_image[a];
		unwritten_reads.push_back(a);
		return 16'h0000;
	endfunction

	function automatic void mem_store(input logic [15:0] a, input logic [15:0] v);
		if (trial) begin
			held_valid = 1'b1;
			held_addr  = a;
			held_data  = v;
		end else begin
			mem_image[a] = v;
			written_addrs.push_back(a);
		end
	endfunction

	function automatic logic [15:0] next_word();
		logic [15:0] w;
		w = mem_load(cpu_pc);
		cpu_pc = cpu_pc + 16'd1;
		return w;
	endfunction

	function automatic operand_t locate(input logic [5:0] code);
		operand_t o;
		o.kind = LOC_LIT;
		o.v = 16'h0000;
		if (code < 6'h08) begin
			o.kind = LOC_REG;
			o.v = {13'd0, code[2:0]};
		end else if (code < OPD_NW_REG) begin
			o.kind = LOC_MEM;
			o.v = cpu_regs[code[2:0]];
		end else if (code < OPD_POP) begin
			o.kind = LOC_MEM;
			o.v = next_word() + cpu_regs[code[2:0]];
		end else if (code == OPD_POP) begin
			o.kind = LOC_MEM;
			o.v = cpu_sp;
			cpu_sp = cpu_sp + 16'd1;
		end else if (code == OPD_PEEK) begin
			o.kind = LOC_MEM;
			o.v = cpu_sp;
		end else if (code == OPD_PUSH) begin
			cpu_sp = cpu_sp - 16'd1;
			o.kind = LOC_MEM;
			o.v = cpu_sp;
		end else if (code == OPD_SP) begin
			o.kind = LOC_SP;
		end else if (code == OPD_PC) begin
			o.kind = LOC_PC;
		end else if (code == OPD_O) begin
			o.kind = LOC_O;
		end else if (code == OPD_NW_MEM) begin
			o.kind = LOC_MEM;
			o.v = next_word();
		end else if (code == OPD_NW_LIT) begin
			o.v = next_word();
		end else begin
			o.v = {11'd0, code[4:0]};
		end
		return o;
	endfunction

	function automatic logic [15:0] fetch_operand(input operand_t o);
		case (o.kind)
			LOC_REG: return cpu_regs[o.v[2:0]];
			LOC_SP:  return cpu_sp;
			LOC_PC:  return cpu_pc;
			LOC_O:   return cpu_o;
			LOC_MEM: return mem_load(o.v);
			default: return o.v;
		endcase
	endfunction

	function automatic void store_operand(input operand_t o, input logic [15:0] v);
		case (o.kind)
			LOC_REG: cpu_regs[o.v[2:0]] = v;
			LOC_SP:  cpu_sp = v;
			LOC_PC:  cpu_pc = v;
			LOC_O:   cpu_o = v;
			LOC_MEM: mem_store(o.v, v);
			default: ;
		endcase
	endfunction

	function automatic bit has_next_word(input logic [5:0] code);
		return (code >= OPD_NW_REG && code < OPD_POP) || code == OPD_NW_MEM ||
			code == OPD_NW_LIT;
	endfunction

	// Runs one instruction at PC and returns 1 for a reserved non-basic opcode.
	function automatic bit run_instruction();
		logic [15:0] w;
		logic [15:0] skipw;
		logic [15:0] av;
		logic [15:0] bv;
		logic [15:0] res;
		logic [15:0] new_o;
		logic [16:0] sum;
		logic [31:0] prod;
		logic [63:0] wide;
		logic [3:0]  op;
		operand_t    la;
		operand_t    lb;
		bit          wr;
		bit          sets_o;
		bit          tested;
		bit          pass;
		w = next_word();
		op = w[3:0];
		if (op == OP_NB) begin
			if (w[9:4] != NB_JSR)
				return 1'b1;
			la = locate(w[15:10]);
			av = fetch_operand(la);
			cpu_sp = cpu_sp - 16'd1;
			mem_store(cpu_sp, cpu_pc);
			cpu_pc = av;
			return 1'b0;
		end
		la = locate(w[9:4]);
		lb = locate(w[15:10]);
		av = fetch_operand(la);
		bv = fetch_operand(lb);
		wr = 1'b1;
		sets_o = 1'b0;
		tested = 1'b0;
		pass = 1'b1;
		res = 16'h0000;
		new_o = 16'h0000;
		case (op)
			OP_SET: res = bv;
			OP_ADD: begin
				sum = {1'b0, av} + {1'b0, bv};
				res = sum[15:0];
				sets_o = 1'b1;
				new_o = {15'd0, sum[16]};
			end
			OP_SUB: begin
				res = av - bv;
				sets_o = 1'b1;
				new_o = (av < bv) ? 16'hFFFF : 16'h0000;
			end
			OP_MUL: begin
				prod = {16'd0, av} * {16'd0, bv};
				res = prod[15:0];
				sets_o = 1'b1;
				new_o = prod[31:16];
			end
			OP_DIV: begin
				sets_o = 1'b1;
				if (bv != 16'd0) begin
					res = av / bv;
					prod = {av, 16'd0} / {16'd0, bv};
					new_o = prod[15:0];
				end
			end
			OP_MOD: res = (bv == 16'd0) ? 16'h0000 : av % bv;
			OP_SHL: begin
				wide = (bv >= 16'd32) ? 64'd0 : ({48'd0, av} << bv);
				res = wide[15:0];
				sets_o = 1'b1;
				new_o = wide[31:16];
			end
			OP_SHR: begin
				res = (bv >= 16'd16) ? 16'h0000 : (av >> bv);
				sets_o = 1'b1;
				prod = (bv >= 16'd32) ? 32'd0 : ({av, 16'd0} >> bv);
				new_o = prod[15:0];
			end
			OP_AND: res = av & bv;
			OP_BOR: res = av | bv;
			OP_XOR: res = av ^ bv;
			OP_IFE: begin wr = 1'b0; tested = 1'b1; pass = (av == bv); end
			OP_IFN: begin wr = 1'b0; tested = 1'b1; pass = (av != bv); end
			OP_IFG: begin wr = 1'b0; tested = 1'b1; pass = (av > bv); end
			default: begin wr = 1'b0; tested = 1'b1; pass = ((av & bv) != 16'd0); end
		endcase
		if (wr)
			store_operand(la, res);
		if (sets_o)
			cpu_o = new_o;
		if (tested && !pass) begin
			// The skipped instruction is only sized, never evaluated.
			skipw = mem_load(cpu_pc);
			if (skipw[3:0] == OP_NB)
				cpu_pc = cpu_pc + 16'd1 + has_next_word(skipw[15:10]);
			else
				cpu_pc = cpu_pc + 16'd1 + has_next_word(skipw[9:4]) +
					has_next_word(skipw[15:10]);
		end
		return 1'b0;
	endfunction

	// Works out the result of one command. In trial mode the CPU state is
	// restored afterwards and memory is left alone.
	function automatic cpu_result_t predict_result(input cmd_word_t c, input bit is_trial);
		cpu_result_t r;
		logic [15:0] sv_regs [8];
		logic [15:0] sv_sp;
		logic [15:0] sv_pc;
		logic [15:0] sv_o;
		sv_regs = cpu_regs;
		sv_sp = cpu_sp;
		sv_pc = cpu_pc;
		sv_o = cpu_o;
		trial = is_trial;
		held_valid = 1'b0;
		r.rd = 16'h0000;
		r.rsv = 1'b0;
		case (c.cmd)
			CMD_WRITE: mem_store(c.addr, c.wdata);
			CMD_READ:  r.rd = mem_load(c.addr);
			CMD_STEP:  r.rsv = run_instruction();
			default: begin
				if (c.sel < 4'd8)
					r.rd = cpu_regs[c.sel[2:0]];
				else if (c.sel == SEL_SP)
					r.rd = cpu_sp;
				else if (c.sel == SEL_PC)
					r.rd = cpu_pc;
				else if (c.sel == SEL_O)
					r.rd = cpu_o;
			end
		endcase
		r.pc = cpu_pc;
		r.ovf = cpu_o;
		if (is_trial) begin
			cpu_regs = sv_regs;
			cpu_sp = sv_sp;
			cpu_pc = sv_pc;
			cpu_o = sv_o;
		end
		trial = 1'b0;
		return r;
	endfunction

	function automatic void commit_word(input cmd_word_t c);
		command_queue.push_back(c);
		result_queue.push_back(predict_result(c, 1'b0));
		n_cmd[c.cmd]++;
	endfunction

	// Queues a command; any never-written word it would read is written first
	// with random content, repeated until the command reads only known words.
	task automatic issue(input logic [1:0] cmd, input logic [15:0] addr,
			input logic [15:0] wdata, input logic [3:0] sel);
		cmd_word_t   c;
		cmd_word_t   fill;
		cpu_result_t dummy;
		int          missing [$];
		c.cmd = cmd;
		c.addr = addr;
		c.wdata = wdata;
		c.sel = sel;
		forever begin
			unwritten_reads.delete();
			dummy = predict_result(c, 1'b1);
			if (unwritten_reads.size() == 0)
				break;
			missing = unwritten_reads;
			foreach (missing[i]) begin
				fill.cmd = CMD_WRITE;
				fill.addr = missing[i][15:0];
				fill.wdata = $urandom;
				fill.sel = $urandom;
				commit_word(fill);
			end
		end
		commit_word(c);
	endtask

	task automatic put_mem(input logic [15:0] addr, input logic [15:0] v);
		issue(CMD_WRITE, addr, v, $urandom);
	endtask

	task automatic step_cpu();
		issue(CMD_STEP, $urandom, $urandom, $urandom);
	endtask

	function automatic logic [15:0] basic(input logic [3:0] op, input logic [5:0] a,
			input logic [5:0] b);
		return {b, a, op};
	endfunction

	function automatic logic [5:0] rand_operand();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 31);
		return $urandom_range(0, 63);
	endfunction

	function automatic logic [15:0] rand_instruction();
		logic [3:0] op;
		op = $urandom_range(0, 15);
		if (op == OP_NB)
			return {rand_operand(), ($urandom_range(0, 3) == 0) ? 6'($urandom) : NB_JSR, OP_NB};
		return basic(op, rand_operand(), rand_operand());
	endfunction

	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 11);
	endfunction

	// Directed programs first: all opcodes but IFN, IFG and IFB, the carry and
	// borrow cases, the divide and modulo by zero, oversized shifts, a write to
	// a literal, a failed test that skips an instruction with two next words,
	// JSR and a reserved non-basic opcode. Then a long random mix of commands.
	initial begin
		int r;
		logic [15:0] prog [$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_WRITE;
		address = 16'h0000;
		data = 16'h0000;
		reg_select = 4'd0;
		out_ready = 1'b0;
		stimulus_done = 1'b0;
		trial = 1'b0;
		held_valid = 1'b0;
		cpu_sp = 16'h0000;
		cpu_pc = 16'h0000;
		cpu_o = 16'h0000;
		foreach (cpu_regs[i])
			cpu_regs[i] = 16'h0000;
		foreach (n_cmd[i])
			n_cmd[i] = 0;

		prog = '{basic(OP_SET, 6'h00, OPD_NW_LIT), 16'hFFFF,
			basic(OP_ADD, 6'h00, OPD_LIT1),
			basic(OP_SUB, 6'h01, OPD_LIT1),
			basic(OP_MUL, 6'h01, OPD_NW_LIT), 16'hFFFF,
			basic(OP_DIV, 6'h01, OPD_LIT0),
			basic(OP_MOD, 6'h01, OPD_LIT0),
			basic(OP_SHL, 6'h01, OPD_NW_LIT), 16'd40,
			basic(OP_SHR, 6'h00, OPD_NW_LIT), 16'd20,
			basic(OP_SET, OPD_NW_LIT, OPD_LIT5), 16'h1234,
			basic(OP_BOR, 6'h02, OPD_NW_LIT), 16'h8001,
			basic(OP_IFE, 6'h02, OPD_LIT1),
			basic(OP_SET, OPD_NW_MEM, OPD_NW_LIT), 16'h0100, 16'h5555,
			basic(OP_AND, 6'h02, OPD_PC),
			basic(OP_XOR, OPD_O, OPD_SP),
			{OPD_LIT5, NB_RSV, OP_NB},
			{OPD_NW_LIT, NB_JSR, OP_NB}, 16'h0030};
		foreach (prog[i])
			put_mem(16'(i), prog[i]);
		put_mem(16'hFFFF, 16'hFFFF);
		issue(CMD_READ, 16'hFFFF, 16'h0000, 4'd15);
		repeat (15)
			step_cpu();
		for (int s = 0; s < 16; s++)
			issue(CMD_REGRD, $urandom, $urandom, 4'(s));

		// Random part: mostly instructions written at PC and then executed,
		// with stray writes, memory reads and register reads in between.
		while (command_queue.size() + n_results < RANDOM_WORDS + 60) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				put_mem(cpu_pc, rand_instruction());
				step_cpu();
			end else if (r < 60) begin
				step_cpu();
			end else if (r < 70) begin
				put_mem($urandom, $urandom);
			end else if (r < 85) begin
				if (written_addrs.size() > 0 && $urandom_range(0, 3) != 0)
					issue(CMD_READ, written_addrs[$urandom_range(0, written_addrs.size() - 1)],
						$urandom, $urandom);
				else
					issue(CMD_READ, $urandom, $urandom, $urandom);
			end else begin
				issue(CMD_REGRD, $urandom, $urandom, $urandom);
			end
			// Let the driver work through the backlog before more is made.
			while (command_queue.size() > 64)
				@(posedge clk);
		end
		stimulus_done = 1'b1;

		wait (command_queue.size() == 0 && !in_valid && result_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d writes, %0d reads, %0d steps, %0d register reads.",
			n_cmd[CMD_WRITE], n_cmd[CMD_READ], n_cmd[CMD_STEP], n_cmd[CMD_REGRD]);
		$display("Checked %0d results, %0d of them reserved opcodes, %0d failures.",
			n_results, n_reserved, n_fail);
		if (n_fail == 0 && result_queue.size() == 0)
			$display("word_cpu_instruction_executor_tb: PASS");
		else
			$display("word_cpu_instruction_executor_tb: FAIL");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		out_took <= out_valid && out_ready;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still expected.",
				cycle_count, result_queue.size());
			$display("word_cpu_instruction_executor_tb: FAIL");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		in_took = 1'b0;
		out_took = 1'b0;
		send_gap = 0;
		recv_stall = 0;
		hold_left = 0;
		hold_done = 1'b0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		n_fail = 0;
		n_results = 0;
		n_reserved = 0;
	end

	// Sender: a word stays on the inputs until it is taken; between words it
	// waits a random gap, and stretches with no gaps come and go.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			in_valid <= 1'b1;
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (command_queue.size() > 0) begin
			drv_word = command_queue.pop_front();
			command <= drv_word.cmd;
			address <= drv_word.addr;
			data <= drv_word.wdata;
			reg_select <= drv_word.sel;
			in_valid <= 1'b1;
			if ($urandom_range(0, 63) == 0)
				send_quiet = !send_quiet;
			send_gap <= draw_gap(send_quiet);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off partway through so that
	// the core fills up and stops taking new words.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!hold_done && n_results == HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (out_ready && !out_took) begin
			out_ready <= 1'b1;
		end else if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 63) == 0)
				recv_quiet = !recv_quiet;
			recv_stall <= draw_gap(recv_quiet);
		end
	end

	// Checker: each delivered word is compared with the oldest expectation.
	always @(posedge clk) begin
		cpu_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (result_queue.size() == 0) begin
				$display("%0t: result with nothing expected: rd %h pc %h o %h rsv %b",
					$time, read_data, program_counter, overflow_word, reserved_op);
				n_fail++;
			end else begin
				want = result_queue.pop_front();
				n_results++;
				if (reserved_op)
					n_reserved++;
				if (read_data !== want.rd) begin
					$display("%0t: read_data expected %h actual %h", $time, want.rd, read_data);
					n_fail++;
				end
				if (program_counter !== want.pc) begin
					$display("%0t: program_counter expected %h actual %h", $time, want.pc,
						program_counter);
					n_fail++;
				end
				if (overflow_word !== want.ovf) begin
					$display("%0t: overflow_word expected %h actual %h", $time, want.ovf,
						overflow_word);
					n_fail++;
				end
				if (reserved_op !== want.rsv) begin
					$display("%0t: reserved_op expected %b actual %b", $time, want.rsv,
						reserved_op);
					n_fail++;
				end
			end
		end
	end
endmodule
